>>> sv/dplq_pkg.sv
// Shared types and constants for the dual priority log queue.
// Used by dplq_front, dplq_back and dual_priority_log_queue_unit; depends on nothing.
`default_nettype none

package dplq_pkg;

    localparam int WORD_W   = 64;
    localparam int LEN_W    = 16;
    localparam int DEPTH_W  = 5;
    localparam int DROP_W   = 32;
    localparam int DELAY_W  = 8;
    localparam int BATCH_W  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [BATCH_W-1:0] BATCH_SIZE_RST   = 4'd4;
    localparam logic [DELAY_W-1:0] BACKLOG_POLL_RST = 8'd1;
    localparam logic [DELAY_W-1:0] IDLE_POLL_RST    = 8'd20;
    localparam logic [LEN_W-1:0]   MAX_LEN_RST      = 16'd256;

    typedef enum logic [1:0] {
        OP_PUSH_RECORD  = 2'd0,
        OP_PUSH_MESSAGE = 2'd1,
        OP_BATCH_DRAIN  = 2'd2,
        OP_DRAIN_ALL    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_PUSH_STATUS = 2'd0,
        KIND_RECORD      = 2'd1,
        KIND_MESSAGE     = 2'd2,
        KIND_DONE        = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BATCH_SIZE   = 2'd0,
        REG_BACKLOG_POLL = 2'd1,
        REG_IDLE_POLL    = 2'd2,
        REG_MAX_LEN      = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        BK_IDLE  = 1'b0,
        BK_DRAIN = 1'b1
    } bk_state_t;

    typedef struct packed {
        logic [BATCH_W-1:0] batch_size;
        logic [DELAY_W-1:0] backlog_poll_delay;
        logic [DELAY_W-1:0] idle_poll_delay;
        logic [LEN_W-1:0]   max_message_length;
    } cfg_t;

    typedef struct packed {
        op_t               op;
        logic [WORD_W-1:0] payload;
        logic [LEN_W-1:0]  length;
    } cmd_t;

    typedef struct packed {
        kind_t              kind;
        logic               accepted;
        logic               dropped_oldest;
        logic [WORD_W-1:0]  item_word;
        logic [LEN_W-1:0]   item_length;
        logic [DEPTH_W-1:0] total_depth;
        logic [DEPTH_W-1:0] depth_high_water;
        logic [DROP_W-1:0]  drop_total;
        logic [DELAY_W-1:0] poll_delay;
        logic               last;
    } res_t;

endpackage

`default_nettype wire

>>> sv/dplq_front.sv
// Front end: takes commands, clamps message lengths, holds them in a two-beat queue.
// Depends on dplq_pkg.
`default_nettype none

module dplq_front
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire  [1:0]                   op,
    input  wire  [dplq_pkg::WORD_W-1:0]  payload,
    input  wire  [dplq_pkg::LEN_W-1:0]   msg_length,
    input  dplq_pkg::cfg_t               cfg,
    output logic                         cmd_valid,
    output dplq_pkg::cmd_t               cmd,
    input  wire                          cmd_pop
);

    dplq_pkg::cmd_t cmd_q [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           push;
    logic           pop;
    dplq_pkg::cmd_t in_cmd;

    assign busy      = (count_reg == 2'd2);
    assign push      = start && !busy;
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = cmd_q[rd_ptr_reg];

    always_comb
    begin
        in_cmd.op      = dplq_pkg::op_t'(op);
        in_cmd.payload = payload;
        // clamp to the configured maximum length
        in_cmd.length  = (msg_length > cfg.max_message_length) ?
                         cfg.max_message_length : msg_length;
    end

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_q[wr_ptr_reg] <= in_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("command queue count out of range");

    a_busy_holds: assert property (@(posedge clk) disable iff (!rst_n)
        busy && !cmd_pop |=> busy)
        else $error("queue emptied without a pop");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_pop && !start && count_reg == 2'd1 |=> !cmd_valid)
        else $error("pop of last entry left queue non-empty");
`endif

endmodule

`default_nettype wire

>>> sv/dplq_back.sv
// Back end: the record and message ring queues and the drain sequencer.
// Depends on dplq_pkg; fed by dplq_front.
`default_nettype none

module dplq_back
#(
    parameter int RECORD_DEPTH  = 8,
    parameter int MESSAGE_DEPTH = 8,
    parameter int RECORD_BITS   = 64
)
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  dplq_pkg::cfg_t      cfg,
    input  wire                 cmd_valid,
    input  dplq_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    output logic                res_valid,
    output dplq_pkg::res_t      res
);

    localparam int RPTR_W = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
    localparam int MPTR_W = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;
    localparam int RCNT_W = $clog2(RECORD_DEPTH + 1);
    localparam int MCNT_W = $clog2(MESSAGE_DEPTH + 1);
    localparam int TOT_W  = $clog2(RECORD_DEPTH + MESSAGE_DEPTH + 1);
    localparam int CMP_W  = (TOT_W > dplq_pkg::BATCH_W) ? TOT_W : dplq_pkg::BATCH_W;

    logic [RECORD_BITS-1:0]       rec_mem [RECORD_DEPTH];
    logic [dplq_pkg::WORD_W-1:0]  msg_hdl_mem [MESSAGE_DEPTH];
    logic [dplq_pkg::LEN_W-1:0]   msg_len_mem [MESSAGE_DEPTH];

    dplq_pkg::bk_state_t          state_reg, state_next;
    logic [RPTR_W-1:0]            rec_rd_ptr_reg, rec_rd_ptr_next;
    logic [RPTR_W-1:0]            rec_wr_ptr_reg, rec_wr_ptr_next;
    logic [RCNT_W-1:0]            rec_count_reg, rec_count_next;
    logic [MPTR_W-1:0]            msg_rd_ptr_reg, msg_rd_ptr_next;
    logic [MPTR_W-1:0]            msg_wr_ptr_reg, msg_wr_ptr_next;
    logic [MCNT_W-1:0]            msg_count_reg, msg_count_next;
    logic [TOT_W-1:0]             hwm_reg, hwm_next;
    logic [dplq_pkg::DROP_W-1:0]  drop_reg, drop_next;
    logic [TOT_W-1:0]             remain_reg, remain_next;
    logic [TOT_W-1:0]             final_depth_reg, final_depth_next;
    logic [dplq_pkg::DELAY_W-1:0] poll_reg, poll_next;
    logic                         res_valid_reg, res_valid_next;
    dplq_pkg::res_t               res_reg, res_next;
    logic [dplq_pkg::WORD_W-1:0]  pop_word_reg;
    logic [dplq_pkg::LEN_W-1:0]   pop_len_reg;

    logic                         rec_wr_en;
    logic                         msg_wr_en;
    logic                         rec_rd_en;
    logic                         msg_rd_en;
    logic                         rec_full;
    logic                         msg_full;
    logic [TOT_W-1:0]             depth;
    logic [TOT_W-1:0]             new_depth;
    logic                         batch_fills;
    logic [TOT_W-1:0]             budget;

    function automatic logic [RPTR_W-1:0] rec_adv(input logic [RPTR_W-1:0] p);
        return (p == RPTR_W'(RECORD_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [MPTR_W-1:0] msg_adv(input logic [MPTR_W-1:0] p);
        return (p == MPTR_W'(MESSAGE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign rec_full    = (rec_count_reg == RCNT_W'(RECORD_DEPTH));
    assign msg_full    = (msg_count_reg == MCNT_W'(MESSAGE_DEPTH));
    assign depth       = TOT_W'(rec_count_reg) + TOT_W'(msg_count_reg);
    assign batch_fills = (CMP_W'(cfg.batch_size) <= CMP_W'(depth));
    assign budget      = batch_fills ? TOT_W'(cfg.batch_size) : depth;
    assign cmd_pop     = (state_reg == dplq_pkg::BK_IDLE) && cmd_valid;
    assign res_valid   = res_valid_reg;

    // popped job data comes from the registered store read
    always_comb
    begin
        res             = res_reg;
        res.item_word   = pop_word_reg;
        res.item_length = pop_len_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dplq_pkg::BK_IDLE:
            begin
                if (cmd_valid && (cmd.op == dplq_pkg::OP_BATCH_DRAIN ||
                                  cmd.op == dplq_pkg::OP_DRAIN_ALL))
                begin
                    state_next = dplq_pkg::BK_DRAIN;
                end
            end
            dplq_pkg::BK_DRAIN:
            begin
                if (remain_reg == '0)
                begin
                    state_next = dplq_pkg::BK_IDLE;
                end
            end
            default: state_next = dplq_pkg::BK_IDLE;
        endcase
    end

    // datapath and result beat
    always_comb
    begin
        rec_rd_ptr_next  = rec_rd_ptr_reg;
        rec_wr_ptr_next  = rec_wr_ptr_reg;
        rec_count_next   = rec_count_reg;
        msg_rd_ptr_next  = msg_rd_ptr_reg;
        msg_wr_ptr_next  = msg_wr_ptr_reg;
        msg_count_next   = msg_count_reg;
        hwm_next         = hwm_reg;
        drop_next        = drop_reg;
        remain_next      = remain_reg;
        final_depth_next = final_depth_reg;
        poll_next        = poll_reg;
        rec_wr_en        = 1'b0;
        msg_wr_en        = 1'b0;
        rec_rd_en        = 1'b0;
        msg_rd_en        = 1'b0;
        new_depth        = depth;
        res_valid_next   = 1'b0;
        res_next         = '0;
        res_next.kind    = dplq_pkg::KIND_PUSH_STATUS;

        unique case (state_reg)
            dplq_pkg::BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        dplq_pkg::OP_PUSH_RECORD:
                        begin
                            if (!rec_full)
                            begin
                                rec_wr_en       = 1'b1;
                                rec_wr_ptr_next = rec_adv(rec_wr_ptr_reg);
                                rec_count_next  = rec_count_reg + 1'b1;
                                new_depth       = depth + 1'b1;
                                res_next.accepted = 1'b1;
                            end
                            hwm_next       = (new_depth > hwm_reg) ? new_depth : hwm_reg;
                            res_valid_next = 1'b1;
                        end
                        dplq_pkg::OP_PUSH_MESSAGE:
                        begin
                            msg_wr_en       = 1'b1;
                            msg_wr_ptr_next = msg_adv(msg_wr_ptr_reg);
                            if (msg_full)
                            begin
                                // drop the oldest to make room
                                msg_rd_ptr_next         = msg_adv(msg_rd_ptr_reg);
                                drop_next               = drop_reg + 1'b1;
                                res_next.dropped_oldest = 1'b1;
                            end
                            else
                            begin
                                msg_count_next    = msg_count_reg + 1'b1;
                                new_depth         = depth + 1'b1;
                                res_next.accepted = 1'b1;
                            end
                            hwm_next       = (new_depth > hwm_reg) ? new_depth : hwm_reg;
                            res_valid_next = 1'b1;
                        end
                        dplq_pkg::OP_BATCH_DRAIN:
                        begin
                            remain_next      = budget;
                            final_depth_next = depth - budget;
                            poll_next        = batch_fills ? cfg.backlog_poll_delay :
                                                             cfg.idle_poll_delay;
                        end
                        dplq_pkg::OP_DRAIN_ALL:
                        begin
                            remain_next      = depth;
                            final_depth_next = '0;
                            poll_next        = '0;
                        end
                        default: ;
                    endcase
                    res_next.total_depth      = dplq_pkg::DEPTH_W'(new_depth);
                    res_next.depth_high_water = dplq_pkg::DEPTH_W'(hwm_next);
                    res_next.drop_total       = drop_next;
                    res_next.last             = 1'b1;
                end
            end
            dplq_pkg::BK_DRAIN:
            begin
                res_valid_next            = 1'b1;
                res_next.total_depth      = dplq_pkg::DEPTH_W'(final_depth_reg);
                res_next.depth_high_water = dplq_pkg::DEPTH_W'(hwm_reg);
                res_next.drop_total       = drop_reg;
                if (remain_reg != '0)
                begin
                    remain_next = remain_reg - 1'b1;
                    // records go out before messages
                    if (rec_count_reg != '0)
                    begin
                        res_next.kind   = dplq_pkg::KIND_RECORD;
                        rec_rd_en       = 1'b1;
                        rec_rd_ptr_next = rec_adv(rec_rd_ptr_reg);
                        rec_count_next  = rec_count_reg - 1'b1;
                    end
                    else
                    begin
                        res_next.kind   = dplq_pkg::KIND_MESSAGE;
                        msg_rd_en       = 1'b1;
                        msg_rd_ptr_next = msg_adv(msg_rd_ptr_reg);
                        msg_count_next  = msg_count_reg - 1'b1;
                    end
                end
                else
                begin
                    res_next.kind       = dplq_pkg::KIND_DONE;
                    res_next.poll_delay = poll_reg;
                    res_next.last       = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= dplq_pkg::BK_IDLE;
            rec_rd_ptr_reg  <= '0;
            rec_wr_ptr_reg  <= '0;
            rec_count_reg   <= '0;
            msg_rd_ptr_reg  <= '0;
            msg_wr_ptr_reg  <= '0;
            msg_count_reg   <= '0;
            hwm_reg         <= '0;
            drop_reg        <= '0;
            remain_reg      <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rec_rd_ptr_reg  <= rec_rd_ptr_next;
            rec_wr_ptr_reg  <= rec_wr_ptr_next;
            rec_count_reg   <= rec_count_next;
            msg_rd_ptr_reg  <= msg_rd_ptr_next;
            msg_wr_ptr_reg  <= msg_wr_ptr_next;
            msg_count_reg   <= msg_count_next;
            hwm_reg         <= hwm_next;
            drop_reg        <= drop_next;
            remain_reg      <= remain_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        final_depth_reg <= final_depth_next;
        poll_reg        <= poll_next;
        res_reg         <= res_next;
        if (rec_rd_en)
        begin
            pop_word_reg <= dplq_pkg::WORD_W'(rec_mem[rec_rd_ptr_reg]);
        end
        else if (msg_rd_en)
        begin
            pop_word_reg <= msg_hdl_mem[msg_rd_ptr_reg];
        end
        else
        begin
            pop_word_reg <= '0;
        end
        if (msg_rd_en)
        begin
            pop_len_reg <= msg_len_mem[msg_rd_ptr_reg];
        end
        else
        begin
            pop_len_reg <= '0;
        end
        if (rec_wr_en)
        begin
            rec_mem[rec_wr_ptr_reg] <= cmd.payload[RECORD_BITS-1:0];
        end
        if (msg_wr_en)
        begin
            msg_hdl_mem[msg_wr_ptr_reg] <= cmd.payload;
            msg_len_mem[msg_wr_ptr_reg] <= cmd.length;
        end
    end

`ifndef NO_ASSERTIONS
    a_push_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.kind == dplq_pkg::KIND_PUSH_STATUS |-> res_reg.last)
        else $error("push status beat not marked last");

    a_pop_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (res_reg.kind == dplq_pkg::KIND_RECORD ||
                          res_reg.kind == dplq_pkg::KIND_MESSAGE) |-> !res_reg.last)
        else $error("popped job beat marked last");

    a_drain_has_jobs: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dplq_pkg::BK_DRAIN && remain_reg != '0 |->
        (rec_count_reg != '0 || msg_count_reg != '0))
        else $error("drain budget exceeds queued jobs");

    a_hwm_covers_depth: assert property (@(posedge clk) disable iff (!rst_n)
        hwm_reg >= depth && rec_count_reg <= RCNT_W'(RECORD_DEPTH) &&
        msg_count_reg <= MCNT_W'(MESSAGE_DEPTH))
        else $error("queue counts or high-water mark inconsistent");
`endif

endmodule

`default_nettype wire

>>> sv/dual_priority_log_queue_unit.sv
// Top level of the dual priority log queue: configuration registers and wiring.
// Depends on dplq_pkg, dplq_front and dplq_back.
//
// Usage: drive op, payload and msg_length with start high; the command is taken at
// a rising edge where busy is low. Ops push a record, push a message (length
// clamped, oldest message dropped when full), run a batch drain or drain all.
// Each result beat sits on the result ports for one cycle with result_valid high;
// last marks the final beat of a command. The receiver cannot stall.
// A push status beat passes a queue entry, then the back end's result register.
// Throughput: the back end retires one push per cycle while it is not draining; a
// drain holds it to load the budget, send one beat per job and then a done beat.
// A two-entry command queue in front keeps start open while the back end drains;
// busy rises only when both entries are waiting.
// Configuration: write cfg_data to register cfg_index while cfg_valid is high;
// cfg_ready is always high. Write only when no command is outstanding.
// Reset clears both queues, counters and the high-water mark, and loads the
// default configuration (batch 4, backlog delay 1, idle delay 20, max length 256).
`default_nettype none

module dual_priority_log_queue_unit
#(
    parameter int RECORD_DEPTH  = 8,
    parameter int MESSAGE_DEPTH = 8,
    parameter int RECORD_BITS   = 64
)
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  [1:0]                       op,
    input  wire  [dplq_pkg::WORD_W-1:0]      payload,
    input  wire  [dplq_pkg::LEN_W-1:0]       msg_length,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [dplq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [dplq_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             result_valid,
    output logic [1:0]                       kind,
    output logic                             accepted,
    output logic                             dropped_oldest,
    output logic [dplq_pkg::WORD_W-1:0]      item_word,
    output logic [dplq_pkg::LEN_W-1:0]       item_length,
    output logic [dplq_pkg::DEPTH_W-1:0]     total_depth,
    output logic [dplq_pkg::DEPTH_W-1:0]     depth_high_water,
    output logic [dplq_pkg::DROP_W-1:0]      drop_total,
    output logic [dplq_pkg::DELAY_W-1:0]     poll_delay,
    output logic                             last
);

    dplq_pkg::cfg_t cfg_reg, cfg_next;
    dplq_pkg::cmd_t cmd;
    dplq_pkg::res_t res;
    logic           cmd_valid;
    logic           cmd_pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (dplq_pkg::cfg_idx_t'(cfg_index))
                dplq_pkg::REG_BATCH_SIZE:
                    cfg_next.batch_size = cfg_data[dplq_pkg::BATCH_W-1:0];
                dplq_pkg::REG_BACKLOG_POLL:
                    cfg_next.backlog_poll_delay = cfg_data[dplq_pkg::DELAY_W-1:0];
                dplq_pkg::REG_IDLE_POLL:
                    cfg_next.idle_poll_delay = cfg_data[dplq_pkg::DELAY_W-1:0];
                dplq_pkg::REG_MAX_LEN:
                    cfg_next.max_message_length = cfg_data[dplq_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.batch_size         <= dplq_pkg::BATCH_SIZE_RST;
            cfg_reg.backlog_poll_delay <= dplq_pkg::BACKLOG_POLL_RST;
            cfg_reg.idle_poll_delay    <= dplq_pkg::IDLE_POLL_RST;
            cfg_reg.max_message_length <= dplq_pkg::MAX_LEN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dplq_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .payload    (payload),
        .msg_length (msg_length),
        .cfg        (cfg_reg),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    dplq_back
    #(
        .RECORD_DEPTH  (RECORD_DEPTH),
        .MESSAGE_DEPTH (MESSAGE_DEPTH),
        .RECORD_BITS   (RECORD_BITS)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_valid (result_valid),
        .res       (res)
    );

    assign kind             = res.kind;
    assign accepted         = res.accepted;
    assign dropped_oldest   = res.dropped_oldest;
    assign item_word        = res.item_word;
    assign item_length      = res.item_length;
    assign total_depth      = res.total_depth;
    assign depth_high_water = res.depth_high_water;
    assign drop_total       = res.drop_total;
    assign poll_delay       = res.poll_delay;
    assign last             = res.last;

endmodule

`default_nettype wire
